@@ rtl/core/swmmm_pkg.sv @@
// Shared types and constants for the stack with min, max and mean.
package swmmm_pkg;

	// Stack depth and derived widths
	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// Mean datapath: 38-bit running sum, 8 fraction bits, 40-bit result
	localparam int SUM_W  = 38;
	localparam int FRAC_W = 8;
	localparam int DIV_W  = SUM_W + FRAC_W;
	localparam int STEP_W = $clog2(DIV_W);
	localparam int MEAN_W = 40;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_LIST  = 2'd2,
		OP_STATS = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

@@ rtl/core/swmmm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module swmmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/stack_with_min_max_mean.sv @@
// LIFO stack of signed 32-bit entries with push, pop, list and min/max/mean stats.
// Push and the empty-stack cases answer straight from the accept; pop reads the RAM first;
// list reads then emits each entry, top first; stats run a RAM walk, sign step,
// 46 divide steps in a shared compare/subtract unit and the output register.
// One item at a time, taken the cycle after its last result leaves; an output stall
// holds the list walk and any waiting result.
// Reset clears the entry count, control state and output register; stack memory is not.
module stack_with_min_max_mean (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  op,
	input  logic signed [31:0] value,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  status,
	output logic signed [31:0] item,
	output logic signed [31:0] largest,
	output logic signed [31:0] smallest,
	output logic signed [39:0] mean_q8,
	output logic        last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_LIST_RD,
		S_LIST_OUT,
		S_STAT_RD,
		S_STAT_ACC,
		S_ABS,
		S_DIV
	} state_t;

	localparam logic [swmmm_pkg::CNT_W-1:0]  FULL_CNT  = swmmm_pkg::CNT_W'(swmmm_pkg::DEPTH);
	localparam logic [swmmm_pkg::STEP_W-1:0] LAST_STEP =
		swmmm_pkg::STEP_W'(swmmm_pkg::DIV_W - 1);

	state_t                                 state_q;
	logic [swmmm_pkg::CNT_W-1:0]            count_q;
	logic [swmmm_pkg::ADDR_W-1:0]           idx_q;
	logic signed [swmmm_pkg::DATA_W-1:0]    hi_q;
	logic signed [swmmm_pkg::DATA_W-1:0]    lo_q;
	logic signed [swmmm_pkg::SUM_W-1:0]     sum_q;
	logic [swmmm_pkg::DIV_W-1:0]            quo_q;
	logic [swmmm_pkg::CNT_W-1:0]            rem_q;
	logic [swmmm_pkg::STEP_W-1:0]           step_q;
	logic                                   neg_q;

	logic                                   res_valid_q;
	swmmm_pkg::status_t                     status_q;
	logic signed [swmmm_pkg::DATA_W-1:0]    item_q;
	logic signed [swmmm_pkg::DATA_W-1:0]    largest_q;
	logic signed [swmmm_pkg::DATA_W-1:0]    smallest_q;
	logic signed [swmmm_pkg::MEAN_W-1:0]    mean_q;
	logic                                   last_q;

	logic                                   cmd_fire;
	logic                                   res_free;
	logic                                   is_full;
	logic                                   is_empty;
	logic                                   idx_is_last;
	logic                                   wr_en;
	logic [swmmm_pkg::ADDR_W-1:0]           wr_addr;
	logic                                   rd_en;
	logic [swmmm_pkg::ADDR_W-1:0]           rd_addr;
	logic [swmmm_pkg::DATA_W-1:0]           rd_data;
	logic signed [swmmm_pkg::DATA_W-1:0]    rd_val;
	logic signed [swmmm_pkg::SUM_W-1:0]     sum_next;
	logic [swmmm_pkg::CNT_W:0]              div_trial;
	logic                                   div_ge;
	logic [swmmm_pkg::CNT_W-1:0]            rem_next;
	logic [swmmm_pkg::SUM_W-1:0]            sum_mag;
	logic [swmmm_pkg::MEAN_W-1:0]           quo_low;

	// Handshake: one item in flight, taken only with an empty output register
	assign cmd_stall = (state_q != S_IDLE) || res_valid_q;
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign res_free  = !res_valid_q || !res_stall;

	assign is_full     = (count_q == FULL_CNT);
	assign is_empty    = (count_q == '0);
	assign idx_is_last = (swmmm_pkg::CNT_W'(idx_q) + swmmm_pkg::CNT_W'(1)) == count_q;

	// RAM control: push writes at count, pop/list/stats read
	always_comb begin
		wr_en   = cmd_fire && (op == swmmm_pkg::OP_PUSH) && !is_full;
		wr_addr = swmmm_pkg::ADDR_W'(count_q);
		rd_en   = 1'b0;
		rd_addr = idx_q;
		unique case (state_q)
			S_IDLE: begin
				rd_en   = cmd_fire && (op == swmmm_pkg::OP_POP) && !is_empty;
				rd_addr = swmmm_pkg::ADDR_W'(count_q - swmmm_pkg::CNT_W'(1));
			end
			S_LIST_RD, S_STAT_RD: begin
				rd_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	swmmm_ram #(
		.WIDTH(swmmm_pkg::DATA_W),
		.DEPTH(swmmm_pkg::DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(value),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Shared datapath: accumulate, magnitude, one restoring divide step
	always_comb begin
		rd_val    = $signed(rd_data);
		sum_next  = sum_q + swmmm_pkg::SUM_W'(rd_val);
		sum_mag   = sum_q[swmmm_pkg::SUM_W-1] ? swmmm_pkg::SUM_W'(-sum_q)
			: swmmm_pkg::SUM_W'(sum_q);
		div_trial = {rem_q, quo_q[swmmm_pkg::DIV_W-1]};
		div_ge    = div_trial >= {1'b0, count_q};
		rem_next  = div_ge ? swmmm_pkg::CNT_W'(div_trial - {1'b0, count_q})
			: swmmm_pkg::CNT_W'(div_trial);
		quo_low   = quo_q[swmmm_pkg::MEAN_W-1:0];
	end

	// Sequencer, stack state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			hi_q        <= '0;
			lo_q        <= '0;
			sum_q       <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			neg_q       <= 1'b0;
			res_valid_q <= 1'b0;
			status_q    <= swmmm_pkg::ST_OK;
			item_q      <= '0;
			largest_q   <= '0;
			smallest_q  <= '0;
			mean_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						status_q   <= swmmm_pkg::ST_OK;
						item_q     <= '0;
						largest_q  <= '0;
						smallest_q <= '0;
						mean_q     <= '0;
						last_q     <= 1'b1;
						unique case (op)
							swmmm_pkg::OP_PUSH: begin
								res_valid_q <= 1'b1;
								if (is_full) begin
									status_q <= swmmm_pkg::ST_FULL;
								end else begin
									count_q <= count_q + swmmm_pkg::CNT_W'(1);
								end
							end
							swmmm_pkg::OP_POP: begin
								if (is_empty) begin
									res_valid_q <= 1'b1;
									status_q    <= swmmm_pkg::ST_EMPTY;
									item_q      <= '1;
								end else begin
									count_q <= count_q - swmmm_pkg::CNT_W'(1);
									state_q <= S_POP;
								end
							end
							swmmm_pkg::OP_LIST: begin
								if (is_empty) begin
									res_valid_q <= 1'b1;
									status_q    <= swmmm_pkg::ST_EMPTY;
								end else begin
									idx_q   <= swmmm_pkg::ADDR_W'(count_q - swmmm_pkg::CNT_W'(1));
									state_q <= S_LIST_RD;
								end
							end
							swmmm_pkg::OP_STATS: begin
								if (is_empty) begin
									res_valid_q <= 1'b1;
									status_q    <= swmmm_pkg::ST_EMPTY;
								end else begin
									idx_q   <= '0;
									state_q <= S_STAT_RD;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				// Popped entry arrives from the RAM
				S_POP: begin
					res_valid_q <= 1'b1;
					item_q      <= rd_val;
					state_q     <= S_IDLE;
				end
				S_LIST_RD: begin
					state_q <= S_LIST_OUT;
				end
				// Emit one entry, top first; bottom entry closes the run
				S_LIST_OUT: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						status_q    <= swmmm_pkg::ST_OK;
						item_q      <= rd_val;
						largest_q   <= '0;
						smallest_q  <= '0;
						mean_q      <= '0;
						last_q      <= (idx_q == '0);
						if (idx_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q - swmmm_pkg::ADDR_W'(1);
							state_q <= S_LIST_RD;
						end
					end
				end
				S_STAT_RD: begin
					state_q <= S_STAT_ACC;
				end
				// Fold one entry into max, min and sum
				S_STAT_ACC: begin
					if (idx_q == '0) begin
						hi_q  <= rd_val;
						lo_q  <= rd_val;
						sum_q <= swmmm_pkg::SUM_W'(rd_val);
					end else begin
						if (rd_val > hi_q) begin
							hi_q <= rd_val;
						end
						if (rd_val < lo_q) begin
							lo_q <= rd_val;
						end
						sum_q <= sum_next;
					end
					if (idx_is_last) begin
						state_q <= S_ABS;
					end else begin
						idx_q   <= idx_q + swmmm_pkg::ADDR_W'(1);
						state_q <= S_STAT_RD;
					end
				end
				// Set up |sum| * 256 as the dividend
				S_ABS: begin
					neg_q   <= sum_q[swmmm_pkg::SUM_W-1];
					quo_q   <= {sum_mag, swmmm_pkg::FRAC_W'(0)};
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= S_DIV;
				end
				// One quotient bit per cycle; sign restored at the end
				S_DIV: begin
					rem_q  <= rem_next;
					quo_q  <= {quo_q[swmmm_pkg::DIV_W-2:0], div_ge};
					step_q <= step_q + swmmm_pkg::STEP_W'(1);
					if (step_q == LAST_STEP) begin
						res_valid_q <= 1'b1;
						status_q    <= swmmm_pkg::ST_OK;
						item_q      <= '0;
						largest_q   <= hi_q;
						smallest_q  <= lo_q;
						mean_q      <= neg_q
							? $signed(-{quo_low[swmmm_pkg::MEAN_W-2:0], div_ge})
							: $signed({quo_low[swmmm_pkg::MEAN_W-2:0], div_ge});
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign status    = status_q;
	assign item      = item_q;
	assign largest   = largest_q;
	assign smallest  = smallest_q;
	assign mean_q8   = mean_q;
	assign last      = last_q;

endmodule

@@ dv/tb_stack_with_min_max_mean.sv @@
// Self-checking testbench for the LIFO stack with min, max and mean statistics.
module tb_stack_with_min_max_mean;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [31:0] VAL_MOST_NEG = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MOST_POS = 32'sh7FFF_FFFF;
	localparam int CYCLE_LIMIT = 1_000_000;
	// longest walk: read and fold per entry, sign step, divider, output
	localparam int TAIL_CYCLES = 2 * swmmm_pkg::DEPTH + 80;
	localparam int MAX_REPORTS = 10;

	// One result as seen on the output side
	typedef struct packed {
		swmmm_pkg::status_t st;
		logic signed [31:0] itm;
		logic signed [31:0] hi;
		logic signed [31:0] lo;
		logic signed [39:0] mean;
		logic               lst;
	} stack_res_t;

	logic               clk;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_stall;
	logic [1:0]         op;
	logic signed [31:0] value;
	logic               res_valid;
	logic               res_stall;
	logic [1:0]         status;
	logic signed [31:0] item;
	logic signed [31:0] largest;
	logic signed [31:0] smallest;
	logic signed [39:0] mean_q8;
	logic               last;

	// Mirror of the stack contents and the results still owed by the block
	logic signed [31:0] mirror_stack [swmmm_pkg::DEPTH];
	int                 mirror_depth;
	stack_res_t         owed_q [$];

	int          snd_idle_pct;
	int          rcv_stall_pct;
	int unsigned err_cnt;
	int unsigned cmd_cnt;
	int unsigned res_cnt;
	int unsigned full_hits;
	int unsigned empty_hits;
	int unsigned stats_hits;
	int unsigned cyc_cnt = 0;
	stack_res_t  got_res;
	stack_res_t  want_res;

	stack_with_min_max_mean DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.op        (op),
		.value     (value),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (status),
		.item      (item),
		.largest   (largest),
		.smallest  (smallest),
		.mean_q8   (mean_q8),
		.last      (last)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Run guard
	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still owed", cyc_cnt,
				owed_q.size());
			$display("tb_stack_with_min_max_mean NOT OK");
			$finish;
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < rcv_stall_pct);
	end

	// Apply one accepted command to the mirror and queue the results it owes
	task automatic apply_stack_op(swmmm_pkg::op_t o, logic signed [31:0] v);
		stack_res_t r;
		longint     acc;
		logic signed [31:0] mx;
		logic signed [31:0] mn;
		int k;
		r = '0;
		r.lst = 1'b1;
		case (o)
		swmmm_pkg::OP_PUSH: begin
			if (mirror_depth >= swmmm_pkg::DEPTH) begin
				r.st = swmmm_pkg::ST_FULL;
				full_hits++;
			end else begin
				mirror_stack[mirror_depth] = v;
				mirror_depth++;
			end
			owed_q.push_back(r);
		end
		swmmm_pkg::OP_POP: begin
			if (mirror_depth == 0) begin
				r.st = swmmm_pkg::ST_EMPTY;
				r.itm = -32'sd1;
				empty_hits++;
			end else begin
				mirror_depth--;
				r.itm = mirror_stack[mirror_depth];
			end
			owed_q.push_back(r);
		end
		swmmm_pkg::OP_LIST: begin
			if (mirror_depth == 0) begin
				r.st = swmmm_pkg::ST_EMPTY;
				empty_hits++;
				owed_q.push_back(r);
			end else begin
				// top of stack first, bottom entry carries last
				for (k = mirror_depth - 1; k >= 0; k--) begin
					r.itm = mirror_stack[k];
					r.lst = (k == 0);
					owed_q.push_back(r);
				end
			end
		end
		default: begin
			if (mirror_depth == 0) begin
				r.st = swmmm_pkg::ST_EMPTY;
				empty_hits++;
			end else begin
				mx = mirror_stack[0];
				mn = mirror_stack[0];
				acc = 0;
				for (k = 0; k < mirror_depth; k++) begin
					if (mirror_stack[k] > mx)
						mx = mirror_stack[k];
					if (mirror_stack[k] < mn)
						mn = mirror_stack[k];
					acc += mirror_stack[k];
				end
				r.hi = mx;
				r.lo = mn;
				// signed division truncates toward zero
				r.mean = (acc * 256) / mirror_depth;
				stats_hits++;
			end
			owed_q.push_back(r);
		end
		endcase
	endtask

	// Send one command: optional idle gap, then hold until accepted
	task automatic send_item(swmmm_pkg::op_t o, logic signed [31:0] v);
		while ($urandom_range(99) < snd_idle_pct) begin
			cmd_valid <= 1'b0;
			op <= 2'($urandom_range(3));
			value <= $urandom;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		op <= o;
		value <= v;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		apply_stack_op(o, v);
		cmd_cnt++;
	endtask

	// Stop sending until every owed result has come back
	task automatic wait_results_done();
		cmd_valid <= 1'b0;
		while (owed_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_value();
		int sel;
		sel = $urandom_range(7);
		case (sel)
		0:       return VAL_MOST_NEG;
		1:       return VAL_MOST_POS;
		2, 3:    return $signed(32'($urandom_range(16))) - 32'sd8;
		default: return $urandom;
		endcase
	endfunction

	// Keep the stack shallow: favor push when near empty, pop when deep
	function automatic swmmm_pkg::op_t pick_op();
		int r;
		int push_pct;
		r = $urandom_range(99);
		push_pct = (mirror_depth < 3) ? 65 : (mirror_depth > 10) ? 25 : 45;
		if (r < push_pct)
			return swmmm_pkg::OP_PUSH;
		if (r < push_pct + 30)
			return swmmm_pkg::OP_POP;
		if (r < push_pct + 30 + (70 - push_pct) / 2)
			return swmmm_pkg::OP_LIST;
		return swmmm_pkg::OP_STATS;
	endfunction

	// Result checker
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			res_cnt++;
			got_res.st = swmmm_pkg::status_t'(status);
			got_res.itm = item;
			got_res.hi = largest;
			got_res.lo = smallest;
			got_res.mean = mean_q8;
			got_res.lst = last;
			if (owed_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("%0t: unexpected result st=%0d item=%0d last=%0d", $realtime,
						status, item, last);
			end else begin
				want_res = owed_q.pop_front();
				if (got_res.st !== want_res.st || got_res.itm !== want_res.itm ||
						got_res.hi !== want_res.hi || got_res.lo !== want_res.lo ||
						got_res.mean !== want_res.mean || got_res.lst !== want_res.lst) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS) begin
						$display("%0t: mismatch exp st=%0d item=%0d max=%0d min=%0d mean=%0d last=%0d",
							$realtime, want_res.st, want_res.itm, want_res.hi, want_res.lo,
							want_res.mean, want_res.lst);
						$display("%0t:          got st=%0d item=%0d max=%0d min=%0d mean=%0d last=%0d",
							$realtime, got_res.st, got_res.itm, got_res.hi, got_res.lo,
							got_res.mean, got_res.lst);
					end
				end
			end
		end
	end

	// Pop, list and stats on an empty stack
	task automatic test_empty_stack();
		send_item(swmmm_pkg::OP_POP, $urandom);
		send_item(swmmm_pkg::OP_LIST, $urandom);
		send_item(swmmm_pkg::OP_STATS, $urandom);
	endtask

	// Extreme values, mean truncated toward zero, full list then pop back to empty
	task automatic test_extremes();
		send_item(swmmm_pkg::OP_PUSH, 32'sd0);
		send_item(swmmm_pkg::OP_PUSH, -32'sd1);
		send_item(swmmm_pkg::OP_PUSH, VAL_MOST_NEG);
		send_item(swmmm_pkg::OP_PUSH, VAL_MOST_POS);
		send_item(swmmm_pkg::OP_PUSH, 32'sd1);
		send_item(swmmm_pkg::OP_STATS, $urandom);
		send_item(swmmm_pkg::OP_LIST, $urandom);
		repeat (5)
			send_item(swmmm_pkg::OP_POP, $urandom);
		send_item(swmmm_pkg::OP_POP, $urandom);
		send_item(swmmm_pkg::OP_PUSH, -32'sd3);
		send_item(swmmm_pkg::OP_STATS, $urandom);
		send_item(swmmm_pkg::OP_LIST, $urandom);
		send_item(swmmm_pkg::OP_POP, $urandom);
	endtask

	// Fill to capacity with one value: widest sum, push on full, full list, a few pops
	task automatic test_full_stack(logic signed [31:0] fill_val);
		repeat (swmmm_pkg::DEPTH)
			send_item(swmmm_pkg::OP_PUSH, fill_val);
		send_item(swmmm_pkg::OP_STATS, $urandom);
		send_item(swmmm_pkg::OP_PUSH, $urandom);
		send_item(swmmm_pkg::OP_LIST, $urandom);
		wait_results_done();
		repeat (4)
			send_item(swmmm_pkg::OP_POP, $urandom);
	endtask

	// Random command mix under one idling setting
	task automatic test_random_mix(int snd_pct, int rcv_pct, int n_items);
		swmmm_pkg::op_t o;
		wait_results_done();
		snd_idle_pct = snd_pct;
		rcv_stall_pct = rcv_pct;
		repeat (n_items) begin
			o = pick_op();
			send_item(o, rand_value());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		op = '0;
		value = '0;
		mirror_depth = 0;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		err_cnt = 0;
		cmd_cnt = 0;
		res_cnt = 0;
		full_hits = 0;
		empty_hits = 0;
		stats_hits = 0;

		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;

		test_empty_stack();
		test_extremes();
		test_full_stack(VAL_MOST_NEG);
		test_random_mix(0, 0, 7);
		test_random_mix(84, 0, 7);
		test_random_mix(0, 84, 7);
		test_random_mix(9, 9, 7);

		wait_results_done();
		repeat (TAIL_CYCLES)
			@(posedge clk);

		$display("Sent %0d commands, checked %0d results in %0d cycles", cmd_cnt, res_cnt,
			cyc_cnt);
		$display("Covered %0d stats with data, %0d pushes on full, %0d ops on empty",
			stats_hits, full_hits, empty_hits);
		if (err_cnt == 0 && owed_q.size() == 0) begin
			$display("tb_stack_with_min_max_mean OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived", err_cnt, owed_q.size());
			$display("tb_stack_with_min_max_mean NOT OK");
		end
		$finish;
	end

endmodule
